[hw/rtl/rawt_pkg.sv]
// ----------------------------------------------------------------------------
// Receive ack window tracker package
// Shared constants, item and result types, and ring arithmetic helpers.
// ----------------------------------------------------------------------------
package rawt_pkg;

  // Default ack window depth in bits
  localparam int unsigned WINDOW_BITS_DEFAULT = 32;

  // Identifier ring runs 1..RING_MAX, zero is skipped
  localparam logic [15:0] RING_MAX = 16'hFFFF;

  // Item kinds
  localparam logic FUNC_SEQUENCE = 1'b0;
  localparam logic FUNC_RELIABLE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] sequence_or_id;
  } item_t;

  typedef struct packed {
    logic        delivered;
    logic [15:0] latest_sequence;
    logic [31:0] ack_window;
    logic [15:0] reliable_ack;
  } result_t;

  // Steps back from a to b in the ring; a crossing of zero loses one step
  function automatic logic [15:0] ring_back(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    if (b > a) begin
      d = d - 16'd1;
    end
    return d;
  endfunction

  // True when a is ahead of b by the sign of the 16-bit difference
  function automatic logic diff_positive(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    return (d != 16'd0) && !d[15];
  endfunction

endpackage

[hw/rtl/rawt_stream_if.sv]
// ----------------------------------------------------------------------------
// Receive ack window tracker stream interface
// Valid/ready channel carrying one item of type T per handshake.
// ----------------------------------------------------------------------------
interface rawt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/receive_ack_window_tracker.sv]
// ----------------------------------------------------------------------------
// Receive ack window tracker
// Tracks the newest datagram sequence, its ack window and in-order reliable ids.
// ----------------------------------------------------------------------------
// Each accepted item passes through the input register, then the result register.
// Throughput: one item per cycle while results are taken; the tracker state updates
// in a single pass of the core. While a result waits, one more item can sit in the
// input register; then input stalls.
// Reset (rst, synchronous): both stages empty, newest sequence 0, window clear,
// expected reliable id 1, no reliable id seen, stop flag clear.
module receive_ack_window_tracker #(
  parameter int unsigned WINDOW_BITS = rawt_pkg::WINDOW_BITS_DEFAULT
) (
  input logic  clk,
  input logic  rst,
  rawt_stream_if.sink   item,
  rawt_stream_if.source result
);

  logic              hold_valid;
  rawt_pkg::item_t   hold;
  logic              out_valid;
  rawt_pkg::result_t out_data;
  rawt_pkg::result_t core_result;
  logic              out_free;
  logic              advance;

  assign out_free   = !out_valid || result.ready;
  assign advance    = hold_valid && out_free;
  assign item.ready = !hold_valid || out_free;

  rawt_core #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (hold),
    .result (core_result)
  );

  // Input register: take an item when empty or whenever the held one moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item.ready) begin
      hold_valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      hold <= item.data;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance;
    end
    if (advance) begin
      out_data <= core_result;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule

[hw/rtl/rawt_core.sv]
// ----------------------------------------------------------------------------
// Receive ack window tracker core
// Holds the tracker state and works out the update and result for one item.
// ----------------------------------------------------------------------------
module rawt_core #(
  parameter int unsigned WINDOW_BITS = rawt_pkg::WINDOW_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  rawt_pkg::item_t   item,
  output rawt_pkg::result_t result
);

  localparam int unsigned DW = $clog2(WINDOW_BITS + 1);

  logic [15:0]            newest_seq;
  logic [WINDOW_BITS-1:0] ack_bits;
  logic [15:0]            expected_id;
  logic                   got_any;
  logic                   stop;

  logic [15:0]            newest_seq_next;
  logic [WINDOW_BITS-1:0] ack_bits_next;
  logic [15:0]            expected_id_next;
  logic                   got_any_next;
  logic                   stop_next;
  logic                   delivered;

  logic [15:0]            value;
  logic                   newer;
  logic [15:0]            ring_dist;
  logic                   in_window;
  logic [DW-1:0]          shift;
  logic [WINDOW_BITS-1:0] mark;
  logic [63:0]            ack_wide;

  assign value = item.sequence_or_id;
  assign newer = rawt_pkg::diff_positive(value, newest_seq);

  // Ring distance between the new sequence and the newest, in whichever direction
  assign ring_dist = newer ? rawt_pkg::ring_back(value, newest_seq)
                           : rawt_pkg::ring_back(newest_seq, value);
  assign in_window = (ring_dist != 16'd0) && (ring_dist <= 16'(WINDOW_BITS));
  assign shift     = ring_dist[DW-1:0];
  assign mark      = WINDOW_BITS'(1) << (shift - DW'(1));

  // Work out the next state for this item
  always_comb begin
    newest_seq_next  = newest_seq;
    ack_bits_next    = ack_bits;
    expected_id_next = expected_id;
    got_any_next     = got_any;
    stop_next        = stop;
    delivered        = 1'b0;
    if (item.func == rawt_pkg::FUNC_SEQUENCE) begin
      stop_next = 1'b0;
      if (value == 16'd0) begin
        // no sequence: window unchanged
      end else if (newest_seq == 16'd0) begin
        newest_seq_next = value;
        ack_bits_next   = '0;
      end else if (value == newest_seq) begin
        // repeat of newest: no change
      end else if (newer) begin
        newest_seq_next = value;
        ack_bits_next   = in_window ? ((ack_bits << shift) | mark) : '0;
      end else if (in_window) begin
        ack_bits_next = ack_bits | mark;
      end
    end else if (!stop && (value != 16'd0)) begin
      if (value == expected_id) begin
        delivered        = 1'b1;
        got_any_next     = 1'b1;
        expected_id_next = (expected_id == rawt_pkg::RING_MAX) ? 16'd1
                                                               : expected_id + 16'd1;
      end else if (rawt_pkg::diff_positive(value, expected_id)) begin
        stop_next = 1'b1;
      end
    end
  end

  // Report the state after the update
  assign ack_wide = 64'(ack_bits_next);

  always_comb begin
    result.delivered       = delivered;
    result.latest_sequence = newest_seq_next;
    result.ack_window      = ack_wide[31:0];
    if (!got_any_next) begin
      result.reliable_ack = 16'd0;
    end else if (expected_id_next <= 16'd1) begin
      result.reliable_ack = rawt_pkg::RING_MAX;
    end else begin
      result.reliable_ack = expected_id_next - 16'd1;
    end
  end

  // Hold state, advance on each item
  always_ff @(posedge clk) begin
    if (rst) begin
      newest_seq  <= 16'd0;
      ack_bits    <= '0;
      expected_id <= 16'd1;
      got_any     <= 1'b0;
      stop        <= 1'b0;
    end else if (step) begin
      newest_seq  <= newest_seq_next;
      ack_bits    <= ack_bits_next;
      expected_id <= expected_id_next;
      got_any     <= got_any_next;
      stop        <= stop_next;
    end
  end

endmodule
